@@ sv/disk_block_to_chs_splitter_defines.svh @@
// Assertion macros used by the splitter module.
`ifndef DISK_BLOCK_TO_CHS_SPLITTER_DEFINES_SVH
`define DISK_BLOCK_TO_CHS_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define DBCS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dbcs: same-cycle check failed");
`define DBCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dbcs: next-cycle check failed");
`else
`define DBCS_ASSERT_IMPL(label, ante, cons)
`define DBCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/dbcs_pkg.sv @@
`default_nettype none

package dbcs_pkg;

	localparam int BLOCK_W  = 24;
	localparam int COUNT_W  = 7;
	localparam int CYL_W    = 24;
	localparam int HEAD_W   = 8;
	localparam int SECTOR_W = 6;
	localparam int XFER_W   = 5;
	localparam int SPT_W    = 6;
	localparam int HEADS_W  = 9;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RX50_MODE         = 2'd2;

	localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd18;
	localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd2;

	localparam int DEF_MAX_TRANSFER_BLOCKS = 18;
	localparam int DEF_MAX_REQUEST_BLOCKS  = 64;

	localparam int XFER_FIELD_MAX = 31;
	localparam int MAX_HEADS      = 256;
	localparam int RX50_SECTORS   = 10;
	localparam int RX50_HALF      = 5;
	localparam int RX50_TRACKS    = 80;

endpackage

`default_nettype wire

@@ sv/dbcs_req_if.sv @@
`default_nettype none

interface dbcs_req_if;
	logic                          valid;
	logic                          ready;
	logic [dbcs_pkg::BLOCK_W-1:0]  start_block;
	logic [dbcs_pkg::COUNT_W-1:0]  block_count;

	modport source (output valid, output start_block, output block_count, input ready);
	modport sink   (input valid, input start_block, input block_count, output ready);
endinterface

`default_nettype wire

@@ sv/dbcs_rsp_if.sv @@
`default_nettype none

interface dbcs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [dbcs_pkg::CYL_W-1:0]     cylinder;
	logic [dbcs_pkg::HEAD_W-1:0]    head;
	logic [dbcs_pkg::SECTOR_W-1:0]  sector;
	logic [dbcs_pkg::XFER_W-1:0]    transfer_blocks;
	logic                           last;

	modport source (output valid, output cylinder, output head, output sector,
		output transfer_blocks, output last, input ready);
	modport sink   (input valid, input cylinder, input head, input sector,
		input transfer_blocks, input last, output ready);
endinterface

`default_nettype wire

@@ sv/disk_block_to_chs_splitter.sv @@
// Splits a disk request (start block, block count) into cylinder/head/sector transfers.
// A request is taken only while the splitter is idle; a zero count is taken and yields
// nothing. The start address is found by one bit-serial divider used twice, one dividend
// bit per cycle: first dividing the block by the sectors per track (10 in RX50 mode), then
// dividing that quotient by the head count (5 in RX50 mode). After that the transfers are
// stepped on incrementally, one per cycle while the output register is empty or being read.
// Results go through an output register, so a new request can be taken while the final
// transfer of the previous one is still waiting at the output.
// Configuration is written through cfg_we, cfg_index and cfg_data and must only change
// while the splitter is idle.
`default_nettype none
`include "disk_block_to_chs_splitter_defines.svh"

module disk_block_to_chs_splitter #(
	parameter int MAX_TRANSFER_BLOCKS = dbcs_pkg::DEF_MAX_TRANSFER_BLOCKS,
	parameter int MAX_REQUEST_BLOCKS  = dbcs_pkg::DEF_MAX_REQUEST_BLOCKS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	dbcs_req_if.sink                               req,
	dbcs_rsp_if.source                             rsp,
	input  wire logic                              cfg_we,
	input  wire logic [dbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dbcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int BLOCK_W  = dbcs_pkg::BLOCK_W;
	localparam int COUNT_W  = dbcs_pkg::COUNT_W;
	localparam int SPT_W    = dbcs_pkg::SPT_W;
	localparam int HEADS_W  = dbcs_pkg::HEADS_W;
	localparam int HEAD_W   = dbcs_pkg::HEAD_W;
	localparam int SECTOR_W = dbcs_pkg::SECTOR_W;
	localparam int XFER_W   = dbcs_pkg::XFER_W;
	localparam int CYL_W    = dbcs_pkg::CYL_W;
	localparam int BIT_W    = $clog2(BLOCK_W);
	localparam int LIMIT    = (MAX_TRANSFER_BLOCKS > dbcs_pkg::XFER_FIELD_MAX) ?
		dbcs_pkg::XFER_FIELD_MAX : ((MAX_TRANSFER_BLOCKS < 1) ? 1 : MAX_TRANSFER_BLOCKS);

	localparam logic [COUNT_W-1:0] LIMIT_V   = COUNT_W'(LIMIT);
	localparam logic [COUNT_W-1:0] REQ_MAX_V = COUNT_W'(MAX_REQUEST_BLOCKS);
	localparam logic [BIT_W-1:0]   LAST_BIT  = BIT_W'(BLOCK_W - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV1,
		ST_DIV2,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [SPT_W-1:0]       spt_q;
	logic [HEADS_W-1:0]     heads_q;
	logic                   rx50_q;
	logic [BLOCK_W-1:0]     sh_q;
	logic [HEADS_W-1:0]     rem_q;
	logic [BIT_W-1:0]       bit_q;
	logic [COUNT_W-1:0]     left_q;
	logic [SPT_W-1:0]       off_q;
	logic [HEAD_W-1:0]      hd_q;
	logic [CYL_W-1:0]       cyl_q;
	logic                   out_valid_q;
	logic [CYL_W-1:0]       out_cyl_q;
	logic [HEAD_W-1:0]      out_head_q;
	logic [SECTOR_W-1:0]    out_sec_q;
	logic [XFER_W-1:0]      out_xfer_q;
	logic                   out_last_q;

	logic [SPT_W-1:0]       spt_eff;
	logic [HEADS_W-1:0]     heads_eff;
	logic [HEADS_W-1:0]     div_w;
	logic [HEADS_W:0]       trial;
	logic [HEADS_W:0]       trial_sub;
	logic                   ge;
	logic [HEADS_W-1:0]     rem_nx;
	logic [BLOCK_W-1:0]     sh_nx;
	logic                   last_bit;

	logic [COUNT_W-1:0]     req_left;
	logic                   req_go;
	logic                   emit_go;
	logic [COUNT_W-1:0]     room;
	logic [COUNT_W-1:0]     min_a;
	logic [COUNT_W-1:0]     cnt;
	logic                   last_w;
	logic [COUNT_W-1:0]     off_sum;
	logic                   sec_wrap;
	logic [HEADS_W-1:0]     hd_inc;
	logic                   hd_wrap;
	logic                   cyl_inc;

	logic [3:0]             rx_s;
	logic [4:0]             rx_p0;
	logic [4:0]             rx_psum;
	logic [4:0]             rx_p;
	logic [SECTOR_W-1:0]    rx_sec;
	logic [CYL_W-1:0]       trk_inc;
	logic [CYL_W-1:0]       trk;

	assign spt_eff   = (spt_q == '0) ? SPT_W'(1) : spt_q;
	assign heads_eff = (heads_q == '0) ? HEADS_W'(1) :
		((heads_q > HEADS_W'(dbcs_pkg::MAX_HEADS)) ? HEADS_W'(dbcs_pkg::MAX_HEADS) : heads_q);

	always_comb begin
		if (state_q == ST_DIV1) begin
			div_w = rx50_q ? HEADS_W'(dbcs_pkg::RX50_SECTORS) : HEADS_W'(spt_eff);
		end else begin
			div_w = rx50_q ? HEADS_W'(dbcs_pkg::RX50_HALF) : heads_eff;
		end
	end

	assign trial     = {rem_q, sh_q[BLOCK_W-1]};
	assign trial_sub = trial - {1'b0, div_w};
	assign ge        = (trial >= {1'b0, div_w});
	assign rem_nx    = ge ? trial_sub[HEADS_W-1:0] : trial[HEADS_W-1:0];
	assign sh_nx     = {sh_q[BLOCK_W-2:0], ge};
	assign last_bit  = (bit_q == LAST_BIT);

	assign req_left = (req.block_count > REQ_MAX_V) ? REQ_MAX_V : req.block_count;
	assign req_go   = req.valid && req.ready;
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	assign room  = COUNT_W'(spt_eff) - COUNT_W'(off_q);
	assign min_a = (left_q < LIMIT_V) ? left_q : LIMIT_V;
	assign cnt   = rx50_q ? COUNT_W'(1) : ((room < min_a) ? room : min_a);
	assign last_w = (left_q == cnt);

	assign off_sum  = COUNT_W'(off_q) + cnt;
	assign sec_wrap = rx50_q ? (off_sum == COUNT_W'(dbcs_pkg::RX50_SECTORS)) :
		(off_sum == COUNT_W'(spt_eff));
	assign hd_inc   = HEADS_W'(hd_q) + HEADS_W'(1);
	assign hd_wrap  = rx50_q ? (hd_inc == HEADS_W'(dbcs_pkg::RX50_HALF)) : (hd_inc == heads_eff);
	assign cyl_inc  = sec_wrap && (rx50_q || hd_wrap);

	// RX50: logical sectors 0-4 map to odd physical sectors, 5-9 to even ones, then skew.
	assign rx_s    = off_q[3:0];
	assign rx_p0   = (rx_s < 4'(dbcs_pkg::RX50_HALF)) ? {rx_s, 1'b0} :
		({rx_s - 4'(dbcs_pkg::RX50_HALF), 1'b0} + 5'd1);
	assign rx_psum = rx_p0 + {1'b0, hd_q[2:0], 1'b0};
	assign rx_p    = (rx_psum >= 5'(dbcs_pkg::RX50_SECTORS)) ?
		(rx_psum - 5'(dbcs_pkg::RX50_SECTORS)) : rx_psum;
	assign rx_sec  = SECTOR_W'(rx_p) + SECTOR_W'(1);
	assign trk_inc = cyl_q + CYL_W'(1);
	assign trk     = (trk_inc == CYL_W'(dbcs_pkg::RX50_TRACKS)) ? '0 : trk_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			spt_q       <= dbcs_pkg::SPT_RESET;
			heads_q     <= dbcs_pkg::HEADS_RESET;
			rx50_q      <= 1'b0;
			sh_q        <= '0;
			rem_q       <= '0;
			bit_q       <= '0;
			left_q      <= '0;
			off_q       <= '0;
			hd_q        <= '0;
			cyl_q       <= '0;
			out_valid_q <= 1'b0;
			out_cyl_q   <= '0;
			out_head_q  <= '0;
			out_sec_q   <= '0;
			out_xfer_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dbcs_pkg::REG_SECTORS_PER_TRACK: spt_q   <= cfg_data[SPT_W-1:0];
					dbcs_pkg::REG_HEAD_COUNT:        heads_q <= cfg_data[HEADS_W-1:0];
					dbcs_pkg::REG_RX50_MODE:         rx50_q  <= cfg_data[0];
					default: ;
				endcase
			end

			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_go) begin
						left_q <= req_left;
						sh_q   <= req.start_block;
						rem_q  <= '0;
						bit_q  <= '0;
						if (req_left != '0) begin
							state_q <= ST_DIV1;
						end
					end
				end
				ST_DIV1: begin
					sh_q  <= sh_nx;
					rem_q <= rem_nx;
					bit_q <= bit_q + BIT_W'(1);
					if (last_bit) begin
						off_q   <= rem_nx[SPT_W-1:0];
						cyl_q   <= sh_nx;
						rem_q   <= '0;
						bit_q   <= '0;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					sh_q  <= sh_nx;
					rem_q <= rem_nx;
					bit_q <= bit_q + BIT_W'(1);
					if (last_bit) begin
						hd_q  <= rem_nx[HEAD_W-1:0];
						bit_q <= '0;
						if (!rx50_q) begin
							cyl_q <= sh_nx;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						out_cyl_q   <= rx50_q ? trk : cyl_q;
						out_head_q  <= rx50_q ? '0 : hd_q;
						out_sec_q   <= rx50_q ? rx_sec : (off_q + SECTOR_W'(1));
						out_xfer_q  <= cnt[XFER_W-1:0];
						out_last_q  <= last_w;
						left_q      <= left_q - cnt;
						off_q       <= sec_wrap ? '0 : off_sum[SPT_W-1:0];
						if (sec_wrap) begin
							hd_q <= hd_wrap ? '0 : hd_inc[HEAD_W-1:0];
						end
						if (cyl_inc) begin
							cyl_q <= cyl_q + CYL_W'(1);
						end
						if (last_w) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready           = (state_q == ST_IDLE);
	assign rsp.valid           = out_valid_q;
	assign rsp.cylinder        = out_cyl_q;
	assign rsp.head            = out_head_q;
	assign rsp.sector          = out_sec_q;
	assign rsp.transfer_blocks = out_xfer_q;
	assign rsp.last            = out_last_q;

	`DBCS_ASSERT_IMPL(a_emit_has_work, state_q == ST_EMIT, left_q != '0)
	`DBCS_ASSERT_NEXT(a_last_ends_request, emit_go && last_w, state_q == ST_IDLE && out_valid_q)
	`DBCS_ASSERT_NEXT(a_div_to_emit, state_q == ST_DIV2 && last_bit, state_q == ST_EMIT)

endmodule

`default_nettype wire

@@ tb/tb_disk_block_to_chs_splitter.sv @@
`timescale 1ns / 1ps

module tb_disk_block_to_chs_splitter;

	localparam int BLOCK_W    = dbcs_pkg::BLOCK_W;
	localparam int COUNT_W    = dbcs_pkg::COUNT_W;
	localparam int CYL_W      = dbcs_pkg::CYL_W;
	localparam int HEAD_W     = dbcs_pkg::HEAD_W;
	localparam int SECTOR_W   = dbcs_pkg::SECTOR_W;
	localparam int XFER_W     = dbcs_pkg::XFER_W;
	localparam int SPT_W      = dbcs_pkg::SPT_W;
	localparam int HEADS_W    = dbcs_pkg::HEADS_W;
	localparam int CFG_IDX_W  = dbcs_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = dbcs_pkg::CFG_DATA_W;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE_WAIT  = 80;
	localparam int BLOCK_TOP    = (1 << BLOCK_W) - 1;

	typedef struct packed {
		logic [BLOCK_W-1:0] start_block;
		logic [COUNT_W-1:0] block_count;
	} disk_req_t;

	typedef struct packed {
		logic [CYL_W-1:0]    cylinder;
		logic [HEAD_W-1:0]   head;
		logic [SECTOR_W-1:0] sector;
		logic [XFER_W-1:0]   transfer_blocks;
		logic                last;
	} chs_xfer_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dbcs_req_if req_ch ();
	dbcs_rsp_if rsp_ch ();

	disk_block_to_chs_splitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	disk_req_t request_q[$];
	chs_xfer_t chs_expected[$];
	disk_req_t held_req;

	logic [SPT_W-1:0]   spt_reg   = dbcs_pkg::SPT_RESET;
	logic [HEADS_W-1:0] heads_reg = dbcs_pkg::HEADS_RESET;
	logic               rx50_reg  = 1'b0;

	logic req_took = 1'b0;
	logic rsp_took = 1'b0;
	logic req_held = 1'b0;
	logic no_idle = 1'b0;
	int unsigned req_gap = 0;
	int unsigned rsp_gap = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Works out every disk transfer that one request turns into.
	function automatic void split_request(input disk_req_t rq);
		int unsigned blk;
		int unsigned left;
		int unsigned spt;
		int unsigned heads;
		int unsigned off;
		int unsigned cnt;
		int unsigned trk;
		int unsigned lsec;
		int unsigned psec;
		chs_xfer_t x;
		blk = rq.start_block;
		left = rq.block_count;
		spt = (spt_reg == 0) ? 1 : spt_reg;
		heads = (heads_reg == 0) ? 1 : heads_reg;
		if (heads > dbcs_pkg::MAX_HEADS) begin
			heads = dbcs_pkg::MAX_HEADS;
		end
		if (left > dbcs_pkg::DEF_MAX_REQUEST_BLOCKS) begin
			left = dbcs_pkg::DEF_MAX_REQUEST_BLOCKS;
		end
		while (left != 0) begin
			if (rx50_reg) begin
				trk = blk / dbcs_pkg::RX50_SECTORS;
				lsec = blk % dbcs_pkg::RX50_SECTORS;
				if (lsec < dbcs_pkg::RX50_HALF) begin
					psec = lsec * 2;
				end else begin
					psec = (lsec - dbcs_pkg::RX50_HALF) * 2 + 1;
				end
				psec = (psec + (trk % dbcs_pkg::RX50_HALF) * 2) % dbcs_pkg::RX50_SECTORS;
				trk = trk + 1;
				if (trk == dbcs_pkg::RX50_TRACKS) begin
					trk = 0;
				end
				x.cylinder = trk[CYL_W-1:0];
				x.head = '0;
				x.sector = SECTOR_W'(psec + 1);
				cnt = 1;
			end else begin
				off = blk % spt;
				cnt = (left < dbcs_pkg::DEF_MAX_TRANSFER_BLOCKS) ? left :
					dbcs_pkg::DEF_MAX_TRANSFER_BLOCKS;
				if (spt - off < cnt) begin
					cnt = spt - off;
				end
				x.cylinder = CYL_W'(blk / (spt * heads));
				x.head = HEAD_W'((blk / spt) % heads);
				x.sector = SECTOR_W'(off + 1);
			end
			left = left - cnt;
			blk = blk + cnt;
			x.transfer_blocks = XFER_W'(cnt);
			x.last = (left == 0);
			chs_expected.push_back(x);
		end
	endfunction

	always @(posedge clk) begin
		chs_xfer_t want;
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		req_took = arst_n && req_ch.valid && req_ch.ready;
		rsp_took = arst_n && rsp_ch.valid && rsp_ch.ready;
		if (rsp_took) begin
			if (chs_expected.size() == 0) begin
				$error("transfer with nothing expected: cyl %0d head %0d sector %0d",
					rsp_ch.cylinder, rsp_ch.head, rsp_ch.sector);
				mismatches++;
			end else begin
				want = chs_expected.pop_front();
				if (rsp_ch.cylinder !== want.cylinder) begin
					$error("cylinder: expected %0d, got %0d", want.cylinder, rsp_ch.cylinder);
					mismatches++;
				end
				if (rsp_ch.head !== want.head) begin
					$error("head: expected %0d, got %0d", want.head, rsp_ch.head);
					mismatches++;
				end
				if (rsp_ch.sector !== want.sector) begin
					$error("sector: expected %0d, got %0d", want.sector, rsp_ch.sector);
					mismatches++;
				end
				if (rsp_ch.transfer_blocks !== want.transfer_blocks) begin
					$error("transfer_blocks: expected %0d, got %0d",
						want.transfer_blocks, rsp_ch.transfer_blocks);
					mismatches++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
					mismatches++;
				end
			end
		end
		if (req_took) begin
			split_request('{start_block: req_ch.start_block, block_count: req_ch.block_count});
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_took && req_held) begin
				req_held = 1'b0;
				req_gap = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (!req_held) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (request_q.size() > 0) begin
					held_req = request_q.pop_front();
					req_held = 1'b1;
				end
			end
			req_ch.valid <= req_held;
			req_ch.start_block <= held_req.start_block;
			req_ch.block_count <= held_req.block_count;
			if (rsp_took) begin
				rsp_gap = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (rsp_gap > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_gap--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic add_request(input int unsigned start, input int unsigned count);
		request_q.push_back('{start_block: start[BLOCK_W-1:0], block_count: count[COUNT_W-1:0]});
	endtask

	task automatic add_random(input int unsigned n);
		int unsigned start;
		int unsigned count;
		int unsigned pick;
		repeat (n) begin
			pick = $urandom_range(0, 4);
			if (pick == 0) begin
				start = $urandom() & BLOCK_TOP;
			end else if (pick == 1) begin
				start = BLOCK_TOP - $urandom_range(0, 100);
			end else if (pick == 2 && rx50_reg) begin
				start = $urandom_range(770, 820);
			end else begin
				start = $urandom_range(0, 3000);
			end
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				count = 0;
			end else if (pick == 1) begin
				count = $urandom_range(65, 127);
			end else if (pick < 4) begin
				count = $urandom_range(21, 64);
			end else begin
				count = $urandom_range(1, 20);
			end
			add_request(start, count);
		end
	endtask

	// Waits until every request has been taken and every transfer has come back.
	task automatic settle();
		do begin
			@(negedge clk);
		end while (request_q.size() != 0 || req_held || chs_expected.size() != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dbcs_pkg::REG_SECTORS_PER_TRACK: spt_reg = value[SPT_W-1:0];
			dbcs_pkg::REG_HEAD_COUNT:        heads_reg = value[HEADS_W-1:0];
			dbcs_pkg::REG_RX50_MODE:         rx50_reg = value[0];
			default: ;
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		held_req = '0;
		req_ch.valid = 1'b0;
		req_ch.start_block = '0;
		req_ch.block_count = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset geometry of 18 sectors and 2 heads.
		add_request(0, 0);
		add_request(0, 1);
		add_request(0, 18);
		add_request(17, 2);
		add_request(5, 18);
		add_request(36, 40);
		add_request(0, 64);
		add_request(0, 127);
		add_request(BLOCK_TOP, 64);
		add_request(BLOCK_TOP, 0);
		add_request(24'hAAAAAA, 7'h55);
		add_request(24'h555555, 7'h2A);
		add_random(12);
		settle();

		no_idle = 1'b1;
		write_reg(dbcs_pkg::REG_SECTORS_PER_TRACK, 63);
		write_reg(dbcs_pkg::REG_HEAD_COUNT, dbcs_pkg::MAX_HEADS);
		add_request(BLOCK_TOP - 10, 64);
		add_request(62, 3);
		add_random(12);
		settle();

		no_idle = 1'b0;
		write_reg(dbcs_pkg::REG_SECTORS_PER_TRACK, 1);
		write_reg(dbcs_pkg::REG_HEAD_COUNT, 1);
		add_request(100, 64);
		add_request(BLOCK_TOP, 3);
		add_random(14);
		settle();

		// A zero geometry behaves as one sector and one head.
		no_idle = 1'b1;
		write_reg(dbcs_pkg::REG_SECTORS_PER_TRACK, 0);
		write_reg(dbcs_pkg::REG_HEAD_COUNT, 0);
		add_request(7, 5);
		add_random(14);
		settle();

		no_idle = 1'b0;
		write_reg(dbcs_pkg::REG_SECTORS_PER_TRACK, 37);
		write_reg(dbcs_pkg::REG_HEAD_COUNT, 511);
		add_request(37 * 256 - 2, 20);
		add_random(14);
		settle();

		write_reg(dbcs_pkg::REG_RX50_MODE, 1);
		write_reg(dbcs_pkg::REG_SECTORS_PER_TRACK, 5);
		add_request(0, 20);
		add_request(790, 20);
		add_request(795, 127);
		add_request(BLOCK_TOP, 3);
		add_request(0, 0);
		add_random(14);
		settle();

		no_idle = 1'b1;
		write_reg(dbcs_pkg::REG_RX50_MODE, 0);
		write_reg(dbcs_pkg::REG_SECTORS_PER_TRACK, 9);
		write_reg(dbcs_pkg::REG_HEAD_COUNT, 5);
		add_random(4);
		settle();
		no_idle = 1'b0;
		add_random(4);
		settle();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
